[hdl/dvrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg: shared types and constants of the distance-vector route table
// Route entry layout, classified command layout, action codes and back-end
// sequencer states.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 32;
  localparam int unsigned Q_DEPTH         = 2;
  localparam int unsigned Q_AW            = 1;

  localparam logic [30:0] COST_INF = 31'h7FFF_FFFF;

  // configuration register indexes
  localparam logic [7:0] CFG_OWN_IP      = 8'd0;
  localparam logic [7:0] CFG_OWN_MAC     = 8'd1;
  localparam logic [7:0] CFG_LIFETIME    = 8'd2;
  localparam logic [7:0] CFG_INITIAL_TTL = 8'd3;

  // input modes
  localparam logic [1:0] MODE_ROUTE = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ACT_DELIVER = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_BCAST   = 3'd2,
    ACT_DROP    = 3'd3,
    ACT_ENTRY   = 3'd4,
    ACT_UPDATED = 3'd5,
    ACT_IGNORED = 3'd6,
    ACT_FULL    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    OP_ROUTE,
    OP_FWD,
    OP_TICK
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_OWN,
    ST_AGE
  } state_e;

  typedef struct packed {
    logic [31:0]       dest;
    logic [47:0]       nh;
    logic [30:0]       cost;
    logic signed [7:0] tm;
  } entry_t;

  typedef struct packed {
    op_e               op;
    logic [31:0]       dest_ip;
    logic              from_local;
    logic              own_dest;
    logic              ignore;
    logic              cost_inf;
    logic [7:0]        ttl_in;
    logic [7:0]        ttl_dec;
    logic [47:0]       nmac;
    logic [47:0]       enh;
    logic [30:0]       sum;
    logic signed [7:0] etime;
  } cmd_t;

endpackage

[hdl/dvrt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_front: command classifier
// Accepts input beats, drops the unused mode, precomputes own-address hits,
// the saturated path cost and the decremented TTL, and pushes a command.
// ----------------------------------------------------------------------------
module dvrt_front import dvrt_pkg::*; (
  input  logic              start_i,
  input  logic              q_full_i,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       dest_ip_i,
  input  logic              from_local_i,
  input  logic [7:0]        ttl_in_i,
  input  logic [47:0]       neighbor_mac_i,
  input  logic [30:0]       link_weight_i,
  input  logic [30:0]       entry_cost_i,
  input  logic signed [7:0] entry_time_i,
  input  logic [47:0]       entry_next_hop_i,
  input  logic [31:0]       own_ip_i,
  input  logic [47:0]       own_mac_i,
  output logic              busy_o,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic [31:0] sum_full;

  assign busy_o   = q_full_i;
  assign sum_full = {1'b0, link_weight_i} + {1'b0, entry_cost_i};

  // classify the beat
  always_comb begin
    push_o = 1'b0;
    cmd_o.op = OP_ROUTE;
    unique case (mode_i)
      MODE_ROUTE: begin
        cmd_o.op = OP_ROUTE;
        push_o   = start_i && !q_full_i;
      end
      MODE_FWD: begin
        cmd_o.op = OP_FWD;
        push_o   = start_i && !q_full_i;
      end
      MODE_TICK: begin
        cmd_o.op = OP_TICK;
        push_o   = start_i && !q_full_i;
      end
      default: push_o = 1'b0;
    endcase
    cmd_o.dest_ip    = dest_ip_i;
    cmd_o.from_local = from_local_i;
    cmd_o.own_dest   = (dest_ip_i == own_ip_i);
    cmd_o.ignore     = (dest_ip_i == own_ip_i) || (entry_next_hop_i == own_mac_i);
    cmd_o.cost_inf   = (entry_cost_i == COST_INF);
    cmd_o.ttl_in     = ttl_in_i;
    cmd_o.ttl_dec    = ttl_in_i - 8'd1;
    cmd_o.nmac       = neighbor_mac_i;
    cmd_o.enh        = entry_next_hop_i;
    // saturate the path cost at infinity
    cmd_o.sum        = sum_full[31] ? COST_INF : sum_full[30:0];
    cmd_o.etime      = entry_time_i;
  end

endmodule

[hdl/dvrt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_queue: command queue
// Short FIFO between the classifier and the table sequencer.
// ----------------------------------------------------------------------------
module dvrt_queue import dvrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              slot_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_q, rd_q;
  logic [Q_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  // store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (Q_AW+1)'(push_i) - (Q_AW+1)'(pop_i);
    end
  end

endmodule

[hdl/dvrt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_back: route table sequencer
// Holds the table memory and fill count, scans it for lookups, applies the
// Bellman-Ford update or forward decision, and ages and dumps it on a tick.
// ----------------------------------------------------------------------------
module dvrt_back import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              pop_o,
  input  logic [31:0]       own_ip_i,
  input  logic [47:0]       own_mac_i,
  input  logic [6:0]        lifetime_i,
  input  logic [7:0]        initial_ttl_i,
  output logic              out_strobe_o,
  output logic [2:0]        action_o,
  output logic [31:0]       out_ip_o,
  output logic [47:0]       out_mac_o,
  output logic [30:0]       out_cost_o,
  output logic signed [7:0] out_time_o,
  output logic [7:0]        ttl_out_o,
  output logic              last_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              chk_v_q, chk_v_d;
  logic [IW-1:0]     chk_idx_q, chk_idx_d;
  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  entry_t            hit_ent_q, hit_ent_d;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rdata_q;
  logic              rd_en;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              strobe_q, strobe_d;
  logic [2:0]        act_q, act_d;
  logic [31:0]       ip_q, ip_d;
  logic [47:0]       mac_q, mac_d;
  logic [30:0]       cost_q, cost_d;
  logic signed [7:0] time_q, time_d;
  logic [7:0]        ttl_q, ttl_d;
  logic              last_q, last_d;

  logic              issue_more;
  logic              scan_done;
  logic signed [8:0] tdec;
  entry_t            aged;

  assign issue_more = (rd_idx_q != cnt_q);
  assign scan_done  = !issue_more && !chk_v_q;

  // age one entry read from the table
  always_comb begin
    tdec = {rdata_q.tm[7], rdata_q.tm} - 9'sd1;
    aged = rdata_q;
    if (tdec <= 9'sd0) begin
      aged.cost = COST_INF;
      aged.tm   = -8'sd1;
    end else begin
      aged.tm = tdec[7:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) state_d = (q_cmd_i.op == OP_TICK) ? ST_OWN : ST_SCAN;
      end
      ST_SCAN: if (scan_done) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      ST_OWN:  state_d = (cnt_q == '0) ? ST_IDLE : ST_AGE;
      ST_AGE:  if (scan_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    pop_o     = 1'b0;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    chk_v_d   = 1'b0;
    chk_idx_d = chk_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    hit_ent_d = hit_ent_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = hit_idx_q;
    wr_data   = hit_ent_q;
    strobe_d  = 1'b0;
    act_d     = ACT_IGNORED;
    ip_d      = '0;
    mac_d     = '0;
    cost_d    = '0;
    time_d    = '0;
    ttl_d     = '0;
    last_d    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o    = 1'b1;
          cmd_d    = q_cmd_i;
          rd_idx_d = '0;
          hit_d    = 1'b0;
        end
      end
      ST_SCAN, ST_AGE: begin
        // issue the next table read
        if (issue_more) begin
          rd_en     = 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end
        if (state_q == ST_SCAN) begin
          // keep the first matching slot
          if (chk_v_q && !hit_q && rdata_q.dest == cmd_q.dest_ip) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            hit_ent_d = rdata_q;
          end
        end else if (chk_v_q) begin
          // write back the aged entry and emit it
          wr_en    = 1'b1;
          wr_addr  = chk_idx_q;
          wr_data  = aged;
          strobe_d = 1'b1;
          act_d    = ACT_ENTRY;
          ip_d     = aged.dest;
          mac_d    = aged.nh;
          cost_d   = aged.cost;
          time_d   = aged.tm;
          last_d   = ({1'b0, chk_idx_q} == (IW+1)'(cnt_q - 1'b1));
        end
      end
      ST_OWN: begin
        strobe_d = 1'b1;
        act_d    = ACT_ENTRY;
        ip_d     = own_ip_i;
        mac_d    = own_mac_i;
        time_d   = signed'({1'b0, lifetime_i});
        last_d   = (cnt_q == '0);
        rd_idx_d = '0;
      end
      ST_EXEC: begin
        strobe_d = 1'b1;
        if (cmd_q.op == OP_FWD) begin
          if (cmd_q.from_local) begin
            if (!hit_q) begin
              act_d = ACT_BCAST;
              ttl_d = initial_ttl_i;
            end else if (hit_ent_q.cost != COST_INF && hit_ent_q.cost != '0 &&
                         hit_ent_q.tm > 8'sd0) begin
              act_d = ACT_SEND;
              mac_d = hit_ent_q.nh;
              ttl_d = initial_ttl_i;
            end else begin
              act_d = ACT_DROP;
            end
          end else if (cmd_q.own_dest) begin
            act_d = ACT_DELIVER;
            ttl_d = cmd_q.ttl_in;
          end else if (cmd_q.ttl_in == '0) begin
            act_d = ACT_DROP;
          end else if (!hit_q) begin
            act_d = ACT_BCAST;
            ttl_d = cmd_q.ttl_dec;
          end else begin
            act_d = ACT_SEND;
            mac_d = hit_ent_q.nh;
            ttl_d = cmd_q.ttl_dec;
          end
        end else begin
          // route entry: Bellman-Ford merge
          act_d = ACT_IGNORED;
          ip_d  = cmd_q.dest_ip;
          if (cmd_q.ignore) begin
            act_d = ACT_IGNORED;
          end else if (cmd_q.cost_inf) begin
            if (hit_q && hit_ent_q.nh == cmd_q.nmac) begin
              wr_en        = 1'b1;
              wr_data.cost = COST_INF;
              wr_data.tm   = -8'sd1;
            end else if (hit_q && hit_ent_q.nh == cmd_q.enh) begin
              wr_en      = 1'b1;
              wr_data.tm = cmd_q.etime;
            end
          end else if (!hit_q) begin
            if (cnt_q == CW'(TABLE_DEPTH)) begin
              act_d = ACT_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[IW-1:0];
              wr_data = '{dest: cmd_q.dest_ip, nh: cmd_q.nmac, cost: cmd_q.sum,
                          tm: cmd_q.etime};
              cnt_d   = cnt_q + 1'b1;
            end
          end else if (cmd_q.sum < hit_ent_q.cost) begin
            wr_en        = 1'b1;
            wr_data.nh   = cmd_q.nmac;
            wr_data.cost = cmd_q.sum;
            wr_data.tm   = cmd_q.etime;
          end else if (hit_ent_q.nh == cmd_q.enh) begin
            wr_en      = 1'b1;
            wr_data.tm = cmd_q.etime;
          end
          if (wr_en) begin
            act_d  = ACT_UPDATED;
            ip_d   = wr_data.dest;
            mac_d  = wr_data.nh;
            cost_d = wr_data.cost;
            time_d = wr_data.tm;
          end
        end
      end
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_idx_q[IW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_ent_q <= hit_ent_d;
    act_q     <= act_d;
    ip_q      <= ip_d;
    mac_q     <= mac_d;
    cost_q    <= cost_d;
    time_q    <= time_d;
    ttl_q     <= ttl_d;
    last_q    <= last_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      chk_v_q  <= 1'b0;
      hit_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      chk_v_q  <= chk_v_d;
      hit_q    <= hit_d;
      strobe_q <= strobe_d;
    end
  end

  assign out_strobe_o = strobe_q;
  assign action_o     = act_q;
  assign out_ip_o     = ip_q;
  assign out_mac_o    = mac_q;
  assign out_cost_o   = cost_q;
  assign out_time_o   = time_q;
  assign ttl_out_o    = ttl_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH)) else $error("fill count beyond depth");
  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> strobe_q && last_q) else $error("exec gave no final result");
  a_hit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> {1'b0, hit_idx_q} < (IW+1)'(cnt_q)) else $error("hit on unfilled slot");
  a_chk_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_v_q |-> {1'b0, chk_idx_q} < (IW+1)'(cnt_q)) else $error("read of unfilled slot");
`endif

endmodule

[hdl/distance_vector_route_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table: distance-vector routing table
// Merges neighbor route entries, answers forward requests and dumps the
// aged table on a tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start_i is high and busy_o is low. busy_o is
//   high while the two-deep command queue is full. Mode 3 beats are taken
//   and discarded.
//   Configuration writes use cfg_valid_i/cfg_ready_o (always ready) with
//   cfg_index_i selecting own_ip, own_mac, lifetime or initial_ttl; other
//   indexes are ignored. Write only while the block is idle.
//   Results appear for one cycle with out_strobe_o; last_o marks the final
//   result of an item. The receiver cannot stall the block.
//   A route entry or forward request scans the N filled slots, then gives
//   its one result from the execute state. A tick gives the own entry first,
//   then the N table entries one per cycle, aged and written back as they
//   are read; the next queued command is taken once the dump is done. The
//   single table memory port pair reads one slot per cycle during a scan.
//   Reset empties the table (fill count zero) and loads register defaults.
// ----------------------------------------------------------------------------
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       dest_ip_i,
  input  logic              from_local_i,
  input  logic [7:0]        ttl_in_i,
  input  logic [47:0]       neighbor_mac_i,
  input  logic [30:0]       link_weight_i,
  input  logic [30:0]       entry_cost_i,
  input  logic signed [7:0] entry_time_i,
  input  logic [47:0]       entry_next_hop_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [47:0]       cfg_data_i,
  output logic              out_strobe_o,
  output logic [2:0]        action_o,
  output logic [31:0]       out_ip_o,
  output logic [47:0]       out_mac_o,
  output logic [30:0]       out_cost_o,
  output logic signed [7:0] out_time_o,
  output logic [7:0]        ttl_out_o,
  output logic              last_o
);

  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic [6:0]  lifetime_q;
  logic [7:0]  initial_ttl_q;

  logic        q_full, q_valid, push, pop;
  cmd_t        push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q      <= '0;
      own_mac_q     <= '0;
      lifetime_q    <= 7'd20;
      initial_ttl_q <= 8'd15;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_IP:      own_ip_q      <= cfg_data_i[31:0];
        CFG_OWN_MAC:     own_mac_q     <= cfg_data_i;
        CFG_LIFETIME:    lifetime_q    <= cfg_data_i[6:0];
        CFG_INITIAL_TTL: initial_ttl_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  dvrt_front u_front (
    .start_i          (start_i),
    .q_full_i         (q_full),
    .mode_i           (mode_i),
    .dest_ip_i        (dest_ip_i),
    .from_local_i     (from_local_i),
    .ttl_in_i         (ttl_in_i),
    .neighbor_mac_i   (neighbor_mac_i),
    .link_weight_i    (link_weight_i),
    .entry_cost_i     (entry_cost_i),
    .entry_time_i     (entry_time_i),
    .entry_next_hop_i (entry_next_hop_i),
    .own_ip_i         (own_ip_q),
    .own_mac_i        (own_mac_q),
    .busy_o           (busy_o),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  dvrt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  dvrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .pop_o         (pop),
    .own_ip_i      (own_ip_q),
    .own_mac_i     (own_mac_q),
    .lifetime_i    (lifetime_q),
    .initial_ttl_i (initial_ttl_q),
    .out_strobe_o  (out_strobe_o),
    .action_o      (action_o),
    .out_ip_o      (out_ip_o),
    .out_mac_o     (out_mac_o),
    .out_cost_o    (out_cost_o),
    .out_time_o    (out_time_o),
    .ttl_out_o     (ttl_out_o),
    .last_o        (last_o)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for distance_vector_route_table
// Drives route entries, forward requests, ticks and unused-mode beats through
// the command port, keeps its own copy of the route table to predict every
// result, and checks each strobed result in order. Configuration changes
// between phases, with sender idling varied per phase.
// ----------------------------------------------------------------------------
module tb_top;
  import dvrt_pkg::*;

  localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned DRAIN_WAIT  = DEPTH + 16;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned N_IPS       = 40;

  typedef struct {
    logic [1:0]        mode;
    logic [31:0]       dest;
    logic              from_local;
    logic [7:0]        ttl;
    logic [47:0]       nmac;
    logic [30:0]       weight;
    logic [30:0]       cost;
    logic signed [7:0] etime;
    logic [47:0]       enh;
    bit                pause;
  } cmd_item_t;

  typedef struct {
    action_e           act;
    logic [31:0]       ip;
    logic [47:0]       mac;
    logic [30:0]       cost;
    logic signed [7:0] tm;
    logic [7:0]        ttl;
    logic              last;
  } route_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        mode_i = '0;
  logic [31:0]       dest_ip_i = '0;
  logic              from_local_i = 1'b0;
  logic [7:0]        ttl_in_i = '0;
  logic [47:0]       neighbor_mac_i = '0;
  logic [30:0]       link_weight_i = '0;
  logic [30:0]       entry_cost_i = '0;
  logic signed [7:0] entry_time_i = '0;
  logic [47:0]       entry_next_hop_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_index_i = '0;
  logic [47:0]       cfg_data_i = '0;
  logic              out_strobe_o;
  logic [2:0]        action_o;
  logic [31:0]       out_ip_o;
  logic [47:0]       out_mac_o;
  logic [30:0]       out_cost_o;
  logic signed [7:0] out_time_o;
  logic [7:0]        ttl_out_o;
  logic              last_o;

  distance_vector_route_table dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the node's registers and table
  logic [31:0]       my_ip;
  logic [47:0]       my_mac;
  logic [6:0]        my_lifetime;
  logic [7:0]        my_ttl;
  bit                tbl_valid [DEPTH];
  logic [31:0]       tbl_dest  [DEPTH];
  logic [47:0]       tbl_nh    [DEPTH];
  logic [30:0]       tbl_cost  [DEPTH];
  logic signed [7:0] tbl_time  [DEPTH];

  cmd_item_t  pending_cmds[$];
  route_res_t expected_res[$];
  cmd_item_t  cur_cmd;
  int         idle_pct = 0;
  int         errors = 0;
  int         stall_cnt = 0;
  logic [31:0] ip_pool [N_IPS];
  logic [47:0] mac_pool [4];

  function automatic route_res_t mk_res(action_e a, logic [31:0] ip, logic [47:0] mac,
                                        logic [30:0] c, logic signed [7:0] t,
                                        logic [7:0] ttl);
    route_res_t r;
    r.act = a; r.ip = ip; r.mac = mac; r.cost = c; r.tm = t; r.ttl = ttl; r.last = 1'b1;
    return r;
  endfunction

  function automatic int lookup_slot(logic [31:0] ip);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_dest[i] == ip) return i;
    return -1;
  endfunction

  function automatic route_res_t slot_res(int s);
    return mk_res(ACT_UPDATED, tbl_dest[s], tbl_nh[s], tbl_cost[s], tbl_time[s], '0);
  endfunction

  // Bellman-Ford merge of one neighbor route entry
  task automatic merge_route(cmd_item_t c);
    int s;
    logic [31:0] sum;
    s = lookup_slot(c.dest);
    if (c.dest == my_ip || c.enh == my_mac) begin
      expected_res.push_back(mk_res(ACT_IGNORED, c.dest, '0, '0, '0, '0));
    end else if (c.cost == COST_INF) begin
      if (s < 0) begin
        expected_res.push_back(mk_res(ACT_IGNORED, c.dest, '0, '0, '0, '0));
      end else if (tbl_nh[s] == c.nmac) begin
        tbl_cost[s] = COST_INF;
        tbl_time[s] = -8'sd1;
        expected_res.push_back(slot_res(s));
      end else if (tbl_nh[s] == c.enh) begin
        tbl_time[s] = c.etime;
        expected_res.push_back(slot_res(s));
      end else begin
        expected_res.push_back(mk_res(ACT_IGNORED, c.dest, '0, '0, '0, '0));
      end
    end else begin
      sum = {1'b0, c.weight} + {1'b0, c.cost};
      if (sum > {1'b0, COST_INF}) sum = {1'b0, COST_INF};
      if (s >= 0 && !(sum[30:0] < tbl_cost[s])) begin
        if (c.enh == tbl_nh[s]) begin
          tbl_time[s] = c.etime;
          expected_res.push_back(slot_res(s));
        end else begin
          expected_res.push_back(mk_res(ACT_IGNORED, c.dest, '0, '0, '0, '0));
        end
      end else begin
        if (s < 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
        end
        if (s < 0) begin
          expected_res.push_back(mk_res(ACT_FULL, c.dest, '0, '0, '0, '0));
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_dest[s]  = c.dest;
          tbl_nh[s]    = c.nmac;
          tbl_cost[s]  = sum[30:0];
          tbl_time[s]  = c.etime;
          expected_res.push_back(slot_res(s));
        end
      end
    end
  endtask

  // work out the results of one accepted command beat
  task automatic predict_route_results(cmd_item_t c);
    int s;
    int t;
    int last_slot;
    route_res_t r;
    case (c.mode)
      MODE_ROUTE: merge_route(c);
      MODE_FWD: begin
        s = lookup_slot(c.dest);
        if (c.from_local) begin
          if (s < 0)
            r = mk_res(ACT_BCAST, '0, '0, '0, '0, my_ttl);
          else if (tbl_cost[s] < COST_INF && tbl_cost[s] > 0 && tbl_time[s] > 0)
            r = mk_res(ACT_SEND, '0, tbl_nh[s], '0, '0, my_ttl);
          else
            r = mk_res(ACT_DROP, '0, '0, '0, '0, '0);
        end else if (c.dest == my_ip) begin
          r = mk_res(ACT_DELIVER, '0, '0, '0, '0, c.ttl);
        end else if (c.ttl == 0) begin
          r = mk_res(ACT_DROP, '0, '0, '0, '0, '0);
        end else if (s < 0) begin
          r = mk_res(ACT_BCAST, '0, '0, '0, '0, c.ttl - 8'd1);
        end else begin
          r = mk_res(ACT_SEND, '0, tbl_nh[s], '0, '0, c.ttl - 8'd1);
        end
        expected_res.push_back(r);
      end
      MODE_TICK: begin
        last_slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i]) continue;
          t = int'(tbl_time[i]) - 1;
          if (t <= 0) begin
            tbl_cost[i] = COST_INF;
            tbl_time[i] = -8'sd1;
          end else begin
            tbl_time[i] = t[7:0];
          end
          last_slot = i;
        end
        r = mk_res(ACT_ENTRY, my_ip, my_mac, '0, $signed({1'b0, my_lifetime}), '0);
        r.last = (last_slot < 0);
        expected_res.push_back(r);
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i]) continue;
          r = slot_res(i);
          r.act = ACT_ENTRY;
          r.last = (i == last_slot);
          expected_res.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // drive command beats from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) predict_route_results(cur_cmd);
      if (!(start_i && busy_o)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct &&
            !(pending_cmds[0].pause && (expected_res.size() > 0 || start_i))) begin
          cur_cmd = pending_cmds.pop_front();
          mode_i           <= cur_cmd.mode;
          dest_ip_i        <= cur_cmd.dest;
          from_local_i     <= cur_cmd.from_local;
          ttl_in_i         <= cur_cmd.ttl;
          neighbor_mac_i   <= cur_cmd.nmac;
          link_weight_i    <= cur_cmd.weight;
          entry_cost_i     <= cur_cmd.cost;
          entry_time_i     <= cur_cmd.etime;
          entry_next_hop_i <= cur_cmd.enh;
          start_i          <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // check each result beat against the oldest expectation; watch for stalls
  always @(posedge clk_i) begin
    route_res_t e;
    if (rst_ni) begin
      if (out_strobe_o) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result action=%0d ip=%h", $time, action_o, out_ip_o);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (action_o !== e.act || out_ip_o !== e.ip || out_mac_o !== e.mac ||
              out_cost_o !== e.cost || out_time_o !== e.tm || ttl_out_o !== e.ttl ||
              last_o !== e.last) begin
            $display("%0t: mismatch expected act=%0d ip=%h mac=%h cost=%h time=%0d ttl=%0d last=%b",
                     $time, e.act, e.ip, e.mac, e.cost, e.tm, e.ttl, e.last);
            $display("%0t:          actual   act=%0d ip=%h mac=%h cost=%h time=%0d ttl=%0d last=%b",
                     $time, action_o, out_ip_o, out_mac_o, out_cost_o, out_time_o,
                     ttl_out_o, last_o);
            errors++;
          end
        end
      end
      if (out_strobe_o || (start_i && !busy_o)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OWN_IP:      my_ip = val[31:0];
      CFG_OWN_MAC:     my_mac = val;
      CFG_LIFETIME:    my_lifetime = val[6:0];
      CFG_INITIAL_TTL: my_ttl = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [6:0] lt, logic [7:0] ttl);
    write_reg(CFG_OWN_IP, {16'd0, ip});
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_LIFETIME, {41'd0, lt});
    write_reg(CFG_INITIAL_TTL, {40'd0, ttl});
  endtask

  // let every queued beat go and every result come back, then settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_cmds.size() > 0 || start_i || expected_res.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic cmd_item_t mk_cmd(logic [1:0] m, logic [31:0] d);
    cmd_item_t c;
    c.mode = m; c.dest = d; c.from_local = 1'b0; c.ttl = 8'd10;
    c.nmac = mac_pool[0]; c.weight = 31'd1; c.cost = 31'd5; c.etime = 8'sd10;
    c.enh = mac_pool[2]; c.pause = 1'b0;
    return c;
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int k;
    k = $urandom_range(99);
    c.mode = (k < 48) ? MODE_ROUTE : (k < 82) ? MODE_FWD : (k < 95) ? MODE_TICK : MODE_UNUSED;
    c.dest = ($urandom_range(99) < 88) ? ip_pool[$urandom_range(N_IPS - 1)] : $urandom;
    c.from_local = 1'($urandom_range(1));
    c.ttl = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
    c.nmac = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(3)]
                                       : {16'($urandom), 32'($urandom)};
    k = $urandom_range(99);
    c.enh = (k < 50) ? mac_pool[$urandom_range(3)] : (k < 58) ? my_mac
                                                   : {16'($urandom), 32'($urandom)};
    c.weight = ($urandom_range(9) == 0) ? 31'h7FFF_FFFE : 31'($urandom_range(200));
    k = $urandom_range(99);
    c.cost = (k < 15) ? COST_INF : (k < 25) ? 31'($urandom) : 31'($urandom_range(500));
    c.etime = 8'($urandom_range(255));
    c.pause = ($urandom_range(49) == 0);
    return c;
  endfunction

  task automatic run_random(int n, int idle);
    idle_pct = idle;
    for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    cmd_item_t c;
    my_ip = '0; my_mac = '0; my_lifetime = 7'd20; my_ttl = 8'd15;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < N_IPS; i++) ip_pool[i] = $urandom;
    for (int i = 0; i < 4; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(ip_pool[0], mac_pool[3], 7'd20, 8'd15);

    // directed: cases of the merge, forward and tick paths
    c = mk_cmd(MODE_TICK, '0);                 pending_cmds.push_back(c); // empty table
    c = mk_cmd(MODE_ROUTE, ip_pool[0]);        pending_cmds.push_back(c); // own address
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.enh = mac_pool[3];
    pending_cmds.push_back(c);                                            // via self
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.cost = COST_INF;
    pending_cmds.push_back(c);                                            // infinite, absent
    c = mk_cmd(MODE_ROUTE, ip_pool[1]);        pending_cmds.push_back(c); // insert
    c = mk_cmd(MODE_ROUTE, ip_pool[2]); c.weight = 31'h7FFF_FFFE; c.cost = 31'h7FFF_FFFE;
    pending_cmds.push_back(c);                                            // saturate
    c = mk_cmd(MODE_ROUTE, ip_pool[2]); c.nmac = mac_pool[1]; c.cost = 31'd0;
    c.weight = 31'd0; c.etime = -8'sd128;
    pending_cmds.push_back(c);                                            // cheaper, zero cost
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.enh = mac_pool[0]; c.cost = 31'd90;
    pending_cmds.push_back(c);                                            // same hop, refresh
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.nmac = mac_pool[2]; c.cost = 31'd90;
    pending_cmds.push_back(c);                                            // worse, ignored
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.cost = COST_INF; c.nmac = mac_pool[1];
    c.enh = mac_pool[0]; c.etime = 8'sd127;
    pending_cmds.push_back(c);                                            // infinite, hop match
    c = mk_cmd(MODE_ROUTE, ip_pool[1]); c.cost = COST_INF; c.nmac = mac_pool[2];
    pending_cmds.push_back(c);                                            // infinite, no match
    c = mk_cmd(MODE_FWD, ip_pool[1]); c.from_local = 1'b1; pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[2]); c.from_local = 1'b1; pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[5]); c.from_local = 1'b1; pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[0]); c.ttl = 8'd255;      pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[1]); c.ttl = 8'd0;        pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[1]); c.ttl = 8'd255;      pending_cmds.push_back(c);
    c = mk_cmd(MODE_FWD, ip_pool[6]); c.ttl = 8'd1;        pending_cmds.push_back(c);
    c = mk_cmd(MODE_UNUSED, ip_pool[1]);                   pending_cmds.push_back(c);
    c = mk_cmd(MODE_TICK, '0);                             pending_cmds.push_back(c);
    c = mk_cmd(MODE_TICK, '0); c.pause = 1'b1;             pending_cmds.push_back(c);
    drain();

    run_random(40, 0);
    configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 7'd127, 8'd255);
    run_random(40, 63);
    configure(32'h0, 48'h0, 7'd1, 8'd0);
    run_random(40, 0);
    configure(ip_pool[3], mac_pool[1], 7'd64, 8'd100);
    run_random(40, 11);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
